@@ rtl/core/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the serial frame receiver: buffer size,
// protocol byte codes, receive phases, event codes and the stage payloads.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Frame buffer depth and the width of the stored-byte counter.
  localparam int BufferBytes = 64;
  localparam int CountW      = $clog2(BufferBytes + 1);

  // Protocol byte codes.
  localparam logic [7:0] CodeSof   = 8'h01;
  localparam logic [7:0] CodeAck   = 8'h06;
  localparam logic [7:0] CodeNak   = 8'h15;
  localparam logic [7:0] CodeCan   = 8'h18;
  localparam logic [7:0] CheckSeed = 8'hFF;

  // Reset values of the configuration registers.
  localparam logic [7:0] MinLenReset  = 8'd3;
  localparam logic [7:0] MaxLenReset  = 8'd64;
  localparam logic [7:0] LastCmdReset = 8'd255;

  typedef enum logic [1:0] {
    CFG_MIN_LEN  = 2'd0,
    CFG_MAX_LEN  = 2'd1,
    CFG_LAST_CMD = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_LEN   = 3'd1,
    PH_TYPE  = 3'd2,
    PH_CMD   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_ACK       = 3'd1,
    EV_NAK       = 3'd2,
    EV_FRAME_OK  = 3'd3,
    EV_CHECK_ERR = 3'd4
  } event_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic       accept_frame;
  } sfr_item_t;

  typedef struct packed {
    event_e     event_res;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       store_valid;
    logic [5:0] store_index;
    logic [7:0] store_byte;
    logic       ack_was_positive;
  } sfr_result_t;

endpackage

@@ rtl/core/sfr_in_stage.sv @@
// ----------------------------------------------------------------------------
// sfr_in_stage
// Input register. Holds one request and hands it to the step logic when
// the result register can take the result.
// ----------------------------------------------------------------------------
module sfr_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  sfr_pkg::sfr_item_t item_i,
  output logic               in_stall_o,
  input  logic               out_busy_i,
  output logic               fire_o,
  output sfr_pkg::sfr_item_t item_o
);
  import sfr_pkg::*;

  logic      vld_q, vld_d;
  sfr_item_t item_q;
  logic      load;

  assign fire_o     = vld_q && !out_busy_i;
  assign in_stall_o = vld_q && out_busy_i;
  assign load       = in_valid_i && !in_stall_o;
  assign item_o     = item_q;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (fire_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

endmodule

@@ rtl/core/sfr_step.sv @@
// ----------------------------------------------------------------------------
// sfr_step
// Receiver state, configuration registers and the per-byte logic that
// turns one request into one result and the next state.
// ----------------------------------------------------------------------------
module sfr_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 fire_i,
  input  sfr_pkg::sfr_item_t   item_i,
  output sfr_pkg::sfr_result_t result_o
);
  import sfr_pkg::*;

  logic [7:0] min_len_q, max_len_q, last_cmd_q;

  phase_e            phase_q, phase_d;
  logic [7:0]        len_q, len_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [7:0]        chk_q, chk_d;
  logic              pend_q, pend_d;
  logic              pos_q, pos_d;

  logic [CountW-1:0]   cnt_next;
  logic [7:0]          len_eff;
  logic                full;
  logic                reached;
  logic                take;
  phase_e              base;
  logic [7:0]          rx;
  sfr_result_t         res;

  assign rx       = item_i.rx_byte;
  assign cnt_next = cnt_q + CountW'(1);
  assign full     = (cnt_q >= CountW'(BufferBytes));
  // The length byte is the first stored byte, so it counts on its own arrival.
  assign len_eff  = (cnt_q == '0) ? rx : len_q;
  assign reached  = ({8'b0, cnt_next} >= {CountW'(0), len_eff});
  assign result_o = res;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    chk_d   = chk_q;
    pend_d  = pend_q;
    pos_d   = pos_q;
    take    = 1'b0;
    base    = phase_q;
    res     = '0;
    res.event_res = EV_NONE;

    if (item_i.action) begin
      pend_d = 1'b1;
      pos_d  = 1'b0;
    end else begin
      unique case (phase_q)
        PH_HUNT: begin
          priority if (rx == CodeSof) begin
            chk_d   = CheckSeed;
            cnt_d   = '0;
            phase_d = PH_LEN;
          end else if (pend_q && rx == CodeAck) begin
            res.event_res = EV_ACK;
            pend_d = 1'b0;
            pos_d  = 1'b1;
          end else if (pend_q && rx == CodeNak) begin
            res.event_res = EV_NAK;
            pend_d = 1'b0;
            pos_d  = 1'b0;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_LEN: begin
          if (rx < min_len_q || rx > max_len_q) begin
            phase_d = PH_HUNT;
          end else begin
            take = 1'b1;
            base = PH_TYPE;
          end
        end
        PH_TYPE: begin
          take = 1'b1;
          base = PH_CMD;
        end
        PH_CMD: begin
          if (cnt_q != '0 && rx > last_cmd_q) begin
            phase_d = PH_HUNT;
          end else begin
            take = 1'b1;
            base = PH_DATA;
          end
        end
        PH_DATA: begin
          take = 1'b1;
          base = PH_DATA;
        end
        PH_CHECK: begin
          res.reply_valid = 1'b1;
          if (item_i.accept_frame) begin
            if (rx == chk_q) begin
              res.reply_byte = CodeAck;
              res.event_res  = EV_FRAME_OK;
            end else begin
              res.reply_byte = CodeNak;
              res.event_res  = EV_CHECK_ERR;
            end
          end else begin
            res.reply_byte = CodeCan;
          end
          phase_d = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase

      // A stored byte advances the phase once more when the count reaches
      // the length; a byte that finds the buffer full moves straight on.
      if (take) begin
        if (!full) begin
          res.store_valid = 1'b1;
          res.store_index = cnt_q[5:0];
          res.store_byte  = rx;
          cnt_d = cnt_next;
          chk_d = chk_q ^ rx;
          if (cnt_q == '0) begin
            len_d = rx;
          end
          phase_d = reached ? phase_e'(3'(base) + 3'd1) : base;
        end else begin
          phase_d = phase_e'(3'(base) + 3'd1);
        end
      end
    end

    res.ack_was_positive = pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
      cnt_q   <= '0;
      chk_q   <= CheckSeed;
      pend_q  <= 1'b0;
      pos_q   <= 1'b1;
    end else if (fire_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      chk_q   <= chk_d;
      pend_q  <= pend_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q  <= MinLenReset;
      max_len_q  <= MaxLenReset;
      last_cmd_q <= LastCmdReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_LEN:  min_len_q  <= cfg_wdata_i;
        CFG_MAX_LEN:  max_len_q  <= cfg_wdata_i;
        CFG_LAST_CMD: last_cmd_q <= cfg_wdata_i;
        default: begin
          min_len_q <= min_len_q;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/sfr_out_stage.sv @@
// ----------------------------------------------------------------------------
// sfr_out_stage
// Result register. Holds one result until the receiver takes it and tells
// the input side when it cannot take another.
// ----------------------------------------------------------------------------
module sfr_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  sfr_pkg::sfr_result_t result_i,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sfr_pkg::sfr_result_t result_o
);
  import sfr_pkg::*;

  logic        vld_q, vld_d;
  sfr_result_t res_q;

  assign busy_o      = vld_q && out_stall_i;
  assign out_valid_o = vld_q;
  assign result_o    = res_q;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

endmodule

@@ rtl/core/serial_frame_receiver_with_ack_unit.sv @@
// ----------------------------------------------------------------------------
// serial_frame_receiver_with_ack_unit
// Serial API frame receiver: frame parsing, checksum, reply and ACK wait.
// ----------------------------------------------------------------------------
// Each input request carries one received byte (action 0) or a notice that
// a frame was sent (action 1), which arms the wait for an ACK or NAK.
// Every request yields exactly one result on the output channel: an event
// code, an optional reply byte (ACK, NAK or CAN), an optional stored byte
// with its buffer index, and the current transmit acknowledge status.
// Both channels use valid and stall; a request moves when valid is high and
// stall is low. Configuration writes (length limits and command limit) go
// through cfg_we_i / cfg_idx_i / cfg_wdata_i while the unit is idle; the user
// must keep to that, the block does not enforce it. A request passes an input
// register and then a result register, and its result is shown from the
// result register. One request is accepted every cycle as long as the
// output side does not stall; the per-byte logic between the two registers
// sets that figure. When the output stalls, the result register holds, the
// input register fills and then in_stall_o rises.
// Reset leaves the receiver hunting for a start of frame with no ACK wait
// armed and the acknowledge status positive, and restores the default
// configuration. There is no clearing pass.
// ----------------------------------------------------------------------------
module serial_frame_receiver_with_ack_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] rx_byte_i,
  input  logic       accept_frame_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] event_res_o,
  output logic       reply_valid_o,
  output logic [7:0] reply_byte_o,
  output logic       store_valid_o,
  output logic [5:0] store_index_o,
  output logic [7:0] store_byte_o,
  output logic       ack_was_positive_o
);
  import sfr_pkg::*;

  sfr_item_t   item_in, item_reg;
  sfr_result_t step_res, out_res;
  logic        fire;
  logic        out_busy;

  assign item_in.action       = action_i;
  assign item_in.rx_byte      = rx_byte_i;
  assign item_in.accept_frame = accept_frame_i;

  sfr_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .item_i     (item_in),
    .in_stall_o (in_stall_o),
    .out_busy_i (out_busy),
    .fire_o     (fire),
    .item_o     (item_reg)
  );

  sfr_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item_reg),
    .result_o    (step_res)
  );

  sfr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (step_res),
    .busy_o      (out_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign event_res_o        = out_res.event_res;
  assign reply_valid_o      = out_res.reply_valid;
  assign reply_byte_o       = out_res.reply_byte;
  assign store_valid_o      = out_res.store_valid;
  assign store_index_o      = out_res.store_index;
  assign store_byte_o       = out_res.store_byte;
  assign ack_was_positive_o = out_res.ack_was_positive;

`ifndef SYNTHESIS
  // The input side only stalls behind a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // A checksum reply and a stored byte never come from the same byte.
  a_reply_or_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(reply_valid_o && store_valid_o))
    else $error("reply and store in one result");

  // A stored byte reports no event.
  a_store_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && store_valid_o) |-> (event_res_o == EV_NONE))
    else $error("event reported with a stored byte");

  // A reply is always one of the three handshake codes.
  a_reply_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reply_valid_o) |->
      (reply_byte_o == CodeAck || reply_byte_o == CodeNak || reply_byte_o == CodeCan))
    else $error("reply byte is not ACK, NAK or CAN");
`endif

endmodule
